// File: rtl/core/ces_pkg.sv
package ces_pkg;

    // Pipeline depths
    localparam int TERM_LAT  = 9;
    localparam int CELL_LAT  = TERM_LAT + 1;
    localparam int SCALE_LAT = 4;

    // Long division by the term index, one 17-bit digit per stage
    localparam int DIG_W = 17;
    localparam int DIG_N = 4;
    localparam int QUO_W = DIG_W * DIG_N;
    localparam int REM_W = 5;
    localparam int MAG_W = 63;

    localparam logic signed [63:0] ONE_Q40  = 64'sh0000_0100_0000_0000;
    localparam logic [MAG_W-1:0]   TERM_MAX = 63'h4000_0000_0000_0000;
    localparam logic [47:0]        OUT_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0]        OUT_MIN_MAG = 48'h8000_0000_0000;
    localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_LO = -65'sh0_7FFF_FFFF_FFFF_FFFF;

    // One word as it travels down the chain of cells
    typedef struct packed {
        logic signed [31:0] xr;
        logic signed [31:0] xi;
        logic signed [63:0] tr;
        logic signed [63:0] ti;
        logic signed [63:0] ex;
        logic signed [63:0] co;
        logic signed [63:0] si;
    } t_lane;

    // Add two Q.40 sums, clamp to +-(2^63-1)
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > SUM_HI) begin
            return 64'(SUM_HI);
        end else if (s < SUM_LO) begin
            return 64'(SUM_LO);
        end
        return 64'(s);
    endfunction

endpackage

// File: rtl/core/complex_exponential_series.sv
// Complex exponential exp(re)*(cos im + j sin im) by truncated Taylor series.
// Arguments are signed Q4.27, results signed Q13.34 and saturated. The block
// takes one word on every clock at which start is high (busy stays low), and
// returns each result on a single-cycle o_valid strobe that cannot be held
// off. Each word passes through a chain of term cells, one per series power,
// each a 10-stage pipeline (magnitude, two 32x32 products, a partial-product
// add, four digit steps dividing by the power, rounding, sign, sum update),
// followed by a 4-stage 64x64 output multiply.
module complex_exponential_series import ces_pkg::*; #(
    parameter int SERIES_LIMIT = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_arg_re,
    input  logic signed [31:0] i_arg_im,
    output logic               o_valid,
    output logic signed [47:0] o_res_re,
    output logic signed [47:0] o_res_im
);

    localparam int NCELL = SERIES_LIMIT - 1;

    t_lane                w_lane [NCELL+1];
    logic [NCELL:0]       w_vld;
    logic [SCALE_LAT-1:0] r_svld;

    // Seed the chain: both first terms and the exp and cosine sums start at one
    assign w_lane[0] = '{xr: i_arg_re, xi: i_arg_im, tr: ONE_Q40, ti: ONE_Q40,
                         ex: ONE_Q40, co: ONE_Q40, si: 64'sd0};
    assign w_vld[0]  = start;
    assign busy      = 1'b0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ces_cell #(.N(g + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_vld[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    ces_scale u_scale_re (
        .i_clk (i_clk),
        .i_a   (w_lane[NCELL].ex),
        .i_b   (w_lane[NCELL].co),
        .o_res (o_res_re)
    );

    ces_scale u_scale_im (
        .i_clk (i_clk),
        .i_a   (w_lane[NCELL].ex),
        .i_b   (w_lane[NCELL].si),
        .o_res (o_res_im)
    );

    // Track the word through the output multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= '0;
        end else begin
            r_svld <= {r_svld[SCALE_LAT-2:0], w_vld[NCELL]};
        end
    end

    assign o_valid = r_svld[SCALE_LAT-1];

endmodule

// File: rtl/core/ces_term.sv
module ces_term import ces_pkg::*; #(
    parameter int N = 1
) (
    input  logic               i_clk,
    input  logic signed [63:0] i_t,
    input  logic signed [31:0] i_x,
    output logic signed [63:0] o_t
);

    localparam logic [27:0]      RECIP = 28'((2**27 + N - 1) / N);
    localparam logic [REM_W-1:0] DIV   = REM_W'(N);

    logic [63:0]       n_tm;
    logic [31:0]       n_xm;
    logic [MAG_W-1:0]  r_tm;
    logic [31:0]       r_xm;
    logic              r_neg_a;
    logic [63:0]       r_plo;
    logic [62:0]       r_phi;
    logic              r_neg_b;
    logic [94:0]       n_p;
    logic [QUO_W-1:0]  r_dq  [DIG_N+1];
    logic [REM_W-1:0]  r_rm  [DIG_N+1];
    logic              r_l26 [DIG_N+1];
    logic              r_ng  [DIG_N+1];
    logic              n_rnd;
    logic [MAG_W-1:0]  n_mag;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg_r;
    logic signed [63:0] r_out;

    // Take magnitudes and the sign of the product
    always_comb begin
        n_tm = i_t[63] ? 64'(-i_t) : 64'(i_t);
        n_xm = i_x[31] ? 32'(-i_x) : 32'(i_x);
    end

    always_ff @(posedge i_clk) begin
        r_tm    <= n_tm[MAG_W-1:0];
        r_xm    <= n_xm;
        r_neg_a <= i_t[63] ^ i_x[31];
    end

    // Two 32x32 partial products
    always_ff @(posedge i_clk) begin
        r_plo   <= 64'(r_tm[31:0]) * 64'(r_xm);
        r_phi   <= 63'(r_tm[62:32]) * 63'(r_xm);
        r_neg_b <= r_neg_a;
    end

    // Join partials, drop the 27 fraction bits of x, keep the rounding bit
    assign n_p = 95'(r_plo) + {r_phi, 32'b0};

    always_ff @(posedge i_clk) begin
        r_dq[0]  <= n_p[94:27];
        r_rm[0]  <= '0;
        r_l26[0] <= n_p[26];
        r_ng[0]  <= r_neg_b;
    end

    // Divide by the term index, most significant digit first
    for (genvar k = 0; k < DIG_N; k++) begin : g_div
        localparam int HI = QUO_W - 1 - k * DIG_W;
        logic [DIG_W+REM_W-1:0] cur;
        logic [49:0]            prod;
        logic [DIG_W-1:0]       qe;
        logic [DIG_W+REM_W:0]   rr;
        logic [DIG_W-1:0]       qd;
        logic [REM_W-1:0]       rd;
        logic [QUO_W-1:0]       n_dq;

        always_comb begin
            cur  = {r_rm[k], r_dq[k][HI -: DIG_W]};
            prod = 50'(cur) * 50'(RECIP);
            qe   = prod[27 +: DIG_W];
            rr   = (DIG_W+REM_W+1)'(cur) - (DIG_W+REM_W+1)'(qe) * (DIG_W+REM_W+1)'(DIV);
            // correct a one-low quotient estimate
            if (rr >= (DIG_W+REM_W+1)'(DIV)) begin
                qd = qe + 1'b1;
                rd = REM_W'(rr - (DIG_W+REM_W+1)'(DIV));
            end else begin
                qd = qe;
                rd = REM_W'(rr);
            end
            n_dq = r_dq[k];
            n_dq[HI -: DIG_W] = qd;
        end

        always_ff @(posedge i_clk) begin
            r_dq[k+1]  <= n_dq;
            r_rm[k+1]  <= rd;
            r_l26[k+1] <= r_l26[k];
            r_ng[k+1]  <= r_ng[k];
        end
    end

    // Round half away from zero, clamp the magnitude
    always_comb begin
        n_rnd = ({r_rm[DIG_N], 1'b0} + (REM_W+1)'(r_l26[DIG_N])) >= {1'b0, DIV};
        if (r_dq[DIG_N] >= QUO_W'(TERM_MAX)) begin
            n_mag = TERM_MAX;
        end else begin
            n_mag = r_dq[DIG_N][MAG_W-1:0] + MAG_W'(n_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg_r <= r_ng[DIG_N];
    end

    // Apply the sign
    always_ff @(posedge i_clk) begin
        r_out <= r_neg_r ? -$signed(64'(r_mag)) : $signed(64'(r_mag));
    end

    assign o_t = r_out;

endmodule

// File: rtl/core/ces_cell.sv
module ces_cell import ces_pkg::*; #(
    parameter int N = 1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    localparam bit ODD  = (N % 2) == 1;
    localparam bit FLIP = ODD ? (((N - 1) / 2) % 2 == 1) : ((N / 2) % 2 == 1);

    logic signed [63:0]  w_tr;
    logic signed [63:0]  w_ti;
    logic signed [63:0]  n_tis;
    t_lane               r_dly [TERM_LAT];
    logic [TERM_LAT-1:0] r_vld;
    t_lane               n_lane;
    t_lane               r_out;
    logic                r_out_vld;

    ces_term #(.N(N)) u_term_re (
        .i_clk (i_clk),
        .i_t   (i_lane.tr),
        .i_x   (i_lane.xr),
        .o_t   (w_tr)
    );

    ces_term #(.N(N)) u_term_im (
        .i_clk (i_clk),
        .i_t   (i_lane.ti),
        .i_x   (i_lane.xi),
        .o_t   (w_ti)
    );

    // Hold the word alongside the term units
    always_ff @(posedge i_clk) begin
        r_dly[0] <= i_lane;
        for (int i = 1; i < TERM_LAT; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[TERM_LAT-2:0], i_valid};
            r_out_vld <= r_vld[TERM_LAT-1];
        end
    end

    // Fold the new terms into the sums
    always_comb begin
        n_tis     = FLIP ? -w_ti : w_ti;
        n_lane    = r_dly[TERM_LAT-1];
        n_lane.tr = w_tr;
        n_lane.ti = w_ti;
        n_lane.ex = sat_add(r_dly[TERM_LAT-1].ex, w_tr);
        if (ODD) begin
            n_lane.si = sat_add(r_dly[TERM_LAT-1].si, n_tis);
        end else begin
            n_lane.co = sat_add(r_dly[TERM_LAT-1].co, n_tis);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_lane;
    end

    assign o_valid = r_out_vld;
    assign o_lane  = r_out;

endmodule

// File: rtl/core/ces_scale.sv
module ces_scale import ces_pkg::*; (
    input  logic               i_clk,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [47:0] o_res
);

    logic [63:0]  n_am;
    logic [63:0]  n_bm;
    logic [62:0]  r_am;
    logic [62:0]  r_bm;
    logic         r_neg1;
    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic         r_neg2;
    logic [126:0] n_s;
    logic         r_over;
    logic [63:0]  r_m;
    logic         r_neg3;
    logic [47:0]  n_mg;
    logic [47:0]  n_res;
    logic [47:0]  r_res;

    // Take magnitudes
    always_comb begin
        n_am = i_a[63] ? 64'(-i_a) : 64'(i_a);
        n_bm = i_b[63] ? 64'(-i_b) : 64'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_am   <= n_am[62:0];
        r_bm   <= n_bm[62:0];
        r_neg1 <= i_a[63] ^ i_b[63];
    end

    // Four 32x32 partial products
    always_ff @(posedge i_clk) begin
        r_p00  <= 64'(r_am[31:0])  * 64'(r_bm[31:0]);
        r_p01  <= 64'(r_am[31:0])  * 64'(r_bm[62:32]);
        r_p10  <= 64'(r_am[62:32]) * 64'(r_bm[31:0]);
        r_p11  <= 64'(r_am[62:32]) * 64'(r_bm[62:32]);
        r_neg2 <= r_neg1;
    end

    // Sum partials with the rounding half, drop to 34 fraction bits
    assign n_s = 127'(r_p00) + (127'(r_p01) << 32) + (127'(r_p10) << 32)
               + (127'(r_p11) << 64) + (127'(1) << 45);

    always_ff @(posedge i_clk) begin
        r_over <= |n_s[126:110];
        r_m    <= n_s[109:46];
        r_neg3 <= r_neg2;
    end

    // Saturate and apply the sign
    always_comb begin
        if (r_neg3) begin
            n_mg  = (r_over || r_m > 64'(OUT_MIN_MAG)) ? OUT_MIN_MAG : r_m[47:0];
            n_res = 48'(49'd0 - 49'(n_mg));
        end else begin
            n_mg  = (r_over || r_m > 64'(OUT_MAX)) ? OUT_MAX : r_m[47:0];
            n_res = n_mg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = $signed(r_res);

endmodule

// File: rtl/core/ces_chk.sv
module ces_chk import ces_pkg::*; #(
    parameter int SERIES_LIMIT = 21
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] i_arg_re,
    input logic signed [31:0] i_arg_im,
    input logic               o_valid,
    input logic signed [47:0] o_res_re,
    input logic signed [47:0] o_res_im
);

    localparam int LAT = (SERIES_LIMIT - 1) * CELL_LAT + SCALE_LAT;

    // Never stall the sender
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Every accepted word yields a strobe after the fixed latency
    a_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result strobe missing");

    // No strobe without a word accepted the latency before
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("spurious result strobe");

    // A zero argument gives exactly one
    a_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_arg_re == 32'sd0 && i_arg_im == 32'sd0) |-> ##LAT
        (o_res_re == 48'sh0004_0000_0000 && o_res_im == 48'sd0))
        else $error("exp(0) is not one");

    // A real argument gives no imaginary part
    a_real_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_arg_im == 32'sd0) |-> ##LAT (o_res_im == 48'sd0))
        else $error("imaginary part on a real argument");

endmodule

bind complex_exponential_series ces_chk #(.SERIES_LIMIT(SERIES_LIMIT)) u_ces_chk (.*);

// File: tb/sv/testbench.sv
module testbench;
    import ces_pkg::*;

    // One accepted argument and its predicted phasor
    typedef struct {
        logic signed [31:0] arg_re;
        logic signed [31:0] arg_im;
    } t_arg;

    typedef struct {
        logic signed [47:0] res_re;
        logic signed [47:0] res_im;
    } t_phasor;

    localparam int N_POWERS = 21;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_arg_re;
    logic signed [31:0] i_arg_im;
    logic               o_valid;
    logic signed [47:0] o_res_re;
    logic signed [47:0] o_res_im;

    t_arg    pending_args[$];
    t_phasor expected_phasors[$];
    int      gap_left;
    int      mismatch_count;
    int      orphan_count;

    complex_exponential_series #(.SERIES_LIMIT(N_POWERS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_arg_re (i_arg_re),
        .i_arg_im (i_arg_im),
        .o_valid  (o_valid),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Next series term: round(t * x / (n * 2^27)), ties away from zero, clamped
    function automatic logic signed [63:0] series_term(input logic signed [63:0] t,
                                                       input logic signed [63:0] x,
                                                       input int n);
        logic [63:0]  mag_t;
        logic [63:0]  mag_x;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] divisor;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        neg     = t[63] ^ x[63];
        mag_t   = t[63] ? -t : t;
        mag_x   = x[63] ? -x : x;
        prod    = {64'd0, mag_t} * {64'd0, mag_x};
        divisor = 128'(n) << 27;
        quo     = prod / divisor;
        rem     = prod % divisor;
        if (quo[127:64] != 0) begin
            mag = 64'd1 << 62;
        end else begin
            mag = quo[63:0];
            if (2 * rem >= divisor) mag = mag + 1;
            if (mag > (64'd1 << 62)) mag = 64'd1 << 62;
        end
        return neg ? -mag : mag;
    endfunction

    // Add two Q.40 sums, clamp to +-(2^63-1)
    function automatic logic signed [63:0] clamp_sum(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -64'sh7FFF_FFFF_FFFF_FFFF;
        return 64'(s);
    endfunction

    // Q.40 times Q.40, rounded to Q.34 and saturated to 48 bits
    function automatic logic signed [47:0] round_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b);
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] prod;
        logic [127:0] mag;
        logic         neg;
        neg   = a[63] ^ b[63];
        mag_a = a[63] ? -a : a;
        mag_b = b[63] ? -b : b;
        prod  = {64'd0, mag_a} * {64'd0, mag_b} + (128'd1 << 45);
        mag   = prod >> 46;
        if (neg) begin
            if (mag > 128'h8000_0000_0000) mag = 128'h8000_0000_0000;
            return -48'(mag);
        end
        if (mag > 128'h7FFF_FFFF_FFFF) mag = 128'h7FFF_FFFF_FFFF;
        return 48'(mag);
    endfunction

    function automatic t_phasor predict_phasor(input t_arg z);
        logic signed [63:0] xr;
        logic signed [63:0] xi;
        logic signed [63:0] tr;
        logic signed [63:0] ti;
        logic signed [63:0] ex;
        logic signed [63:0] co;
        logic signed [63:0] si;
        t_phasor            p;
        xr = 64'(z.arg_re);
        xi = 64'(z.arg_im);
        tr = ONE_Q40;
        ti = ONE_Q40;
        ex = ONE_Q40;
        co = ONE_Q40;
        si = 0;
        for (int n = 1; n < N_POWERS; n++) begin
            tr = series_term(tr, xr, n);
            ti = series_term(ti, xi, n);
            ex = clamp_sum(ex, tr);
            if (n % 2 == 1) si = clamp_sum(si, (((n - 1) / 2) % 2 == 1) ? -ti : ti);
            else            co = clamp_sum(co, ((n / 2) % 2 == 1) ? -ti : ti);
        end
        p.res_re = round_product(ex, co);
        p.res_im = round_product(ex, si);
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] random_arg();
        int r;
        r = $urandom_range(0, 3);
        case (r)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
            2: return 32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
            default: return {{4{$urandom_range(0, 1) == 1}}, 28'($urandom)};
        endcase
    endfunction

    // Drive the next argument word; hold it while busy
    always @(posedge i_clk) begin
        t_arg z;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                z.arg_re = i_arg_re;
                z.arg_im = i_arg_im;
                expected_phasors.push_back(predict_phasor(z));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (pending_args.size() > 0) begin
                    z = pending_args.pop_front();
                    start    <= 1'b1;
                    i_arg_re <= z.arg_re;
                    i_arg_im <= z.arg_im;
                    gap_left <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_phasor want;
        if (i_rst_n && o_valid) begin
            if (expected_phasors.size() == 0) begin
                orphan_count++;
                if (mismatch_count + orphan_count <= 10)
                    $display("unexpected result re=%h im=%h", o_res_re, o_res_im);
            end else begin
                want = expected_phasors.pop_front();
                if (o_res_re !== want.res_re || o_res_im !== want.res_im) begin
                    mismatch_count++;
                    if (mismatch_count + orphan_count <= 10)
                        $display("mismatch: re exp %h got %h, im exp %h got %h",
                                 want.res_re, o_res_re, want.res_im, o_res_im);
                end
            end
        end
    end

    task automatic add_arg(input logic [31:0] re, input logic [31:0] im);
        t_arg z;
        z.arg_re = re;
        z.arg_im = im;
        pending_args.push_back(z);
    endtask

    initial begin
        logic [31:0] corners[8];
        corners = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0800_0000,
                    32'hF800_0000, 32'h1921_FB54, 32'h7800_0000, 32'h1};
        mismatch_count = 0;
        orphan_count   = 0;
        start    = 1'b0;
        i_arg_re = '0;
        i_arg_im = '0;
        i_rst_n  = 1'b0;
        // Directed corners: zero, full-scale ends, +-1, pi, near-16 overflow
        for (int a = 0; a < 8; a++)
            for (int b = 0; b < 3; b++)
                add_arg(corners[a], corners[(a + b * 3) % 8]);
        for (int k = 0; k < 800; k++)
            add_arg(random_arg(), random_arg());
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Drain, then allow the pipeline latency to pass
        while (pending_args.size() > 0 || start || expected_phasors.size() > 0)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (mismatch_count == 0 && orphan_count == 0 && expected_phasors.size() == 0)
            $display("PASS complex_exponential_series");
        else
            $display("FAIL complex_exponential_series");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL complex_exponential_series");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/ces_pkg.sv
rtl/core/ces_term.sv
rtl/core/ces_cell.sv
rtl/core/ces_scale.sv
rtl/core/complex_exponential_series.sv
rtl/core/ces_chk.sv
tb/sv/testbench.sv
